// ===== src/c_escape_sequence_decoder_top_defines.svh =====
// assertion macros shared by the decoder modules
`ifndef C_ESCAPE_SEQUENCE_DECODER_TOP_DEFINES_SVH
`define C_ESCAPE_SEQUENCE_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge out of reset
`define CSED_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when cond holds, nxt holds in the cycle after
`define CSED_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error(msg);

`else

`define CSED_ASSERT(label, clk, rst_n, prop, msg)
`define CSED_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)

`endif

`endif

// ===== src/csed_pkg.sv =====
package csed_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_CR   = 3'd2,
    PH_OCT  = 3'd3,
    PH_HEX  = 3'd4
  } phase_t;

  localparam logic [1:0] ST_CHAR      = 2'd0;
  localparam logic [1:0] ST_END       = 2'd1;
  localparam logic [1:0] ST_BAD_ESC   = 2'd2;
  localparam logic [1:0] ST_SHORT_HEX = 2'd3;

  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } result_t;

  // an entry holds the one or two results of one input byte
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t head;
  } q_head_t;

endpackage

// ===== src/csed_front.sv =====
`include "c_escape_sequence_decoder_top_defines.svh"

module csed_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              push,
  output csed_pkg::entry_t  push_data
);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChBs    = 8'h5C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChDquot = 8'h22;
  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChV     = 8'h76;
  localparam logic [7:0] ChX     = 8'h78;

  csed_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]      accum_r, accum_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  logic             accept;
  logic             is_oct;
  logic             hex_ok;
  logic [3:0]       hex_d;
  logic [1:0]       oct_cnt;
  logic             f_emit;
  csed_pkg::result_t f_res;
  csed_pkg::phase_t f_phase;
  logic [1:0]       n_res;

  assign accept  = in_valid && in_ready;
  assign is_oct  = (in_byte[7:3] == 5'b00110);
  assign oct_cnt = cnt_r + 2'd1;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_d = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_d = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  // byte handled as new input
  always_comb begin
    f_emit        = 1'b1;
    f_phase       = csed_pkg::PH_IDLE;
    f_res.value   = {24'd0, in_byte};
    f_res.status  = csed_pkg::ST_CHAR;
    if (in_byte == ChNul) begin
      f_res.value  = 32'd0;
      f_res.status = csed_pkg::ST_END;
    end else if (in_byte == ChBs) begin
      f_emit  = 1'b0;
      f_phase = csed_pkg::PH_ESC;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    cnt_nxt   = cnt_r;
    unique case (phase_r)
      csed_pkg::PH_ESC: begin
        phase_nxt = csed_pkg::PH_IDLE;
        if (in_byte == ChCr) begin
          phase_nxt = csed_pkg::PH_CR;
        end else if (in_byte == ChX) begin
          phase_nxt = csed_pkg::PH_HEX;
          accum_nxt = 32'd0;
          cnt_nxt   = 2'd0;
        end else if (is_oct) begin
          phase_nxt = csed_pkg::PH_OCT;
          accum_nxt = {29'd0, in_byte[2:0]};
          cnt_nxt   = 2'd1;
        end
      end
      csed_pkg::PH_CR: begin
        phase_nxt = (in_byte == ChLf) ? csed_pkg::PH_IDLE : f_phase;
      end
      csed_pkg::PH_OCT: begin
        if (is_oct) begin
          accum_nxt = {accum_r[28:0], in_byte[2:0]};
          cnt_nxt   = oct_cnt;
          if (oct_cnt == 2'd3) phase_nxt = csed_pkg::PH_IDLE;
        end else begin
          phase_nxt = f_phase;
        end
      end
      csed_pkg::PH_HEX: begin
        if (hex_ok) begin
          accum_nxt = {accum_r[27:0], hex_d};
          if (cnt_r < 2'd2) cnt_nxt = cnt_r + 2'd1;
        end else begin
          phase_nxt = f_phase;
        end
      end
      default: phase_nxt = f_phase;
    endcase
  end

  // results of this byte
  always_comb begin
    n_res               = 2'd0;
    push_data.r0.value  = 32'd0;
    push_data.r0.status = csed_pkg::ST_CHAR;
    push_data.r1        = f_res;
    unique case (phase_r)
      csed_pkg::PH_ESC: begin
        n_res = 2'd1;
        case (in_byte)
          ChQuote, ChDquot, ChQmark, ChBs: push_data.r0.value = {24'd0, in_byte};
          ChCr, ChLf, ChX:                 n_res = 2'd0;
          ChA:                             push_data.r0.value = 32'd7;
          ChB:                             push_data.r0.value = 32'd8;
          ChF:                             push_data.r0.value = 32'd12;
          ChN:                             push_data.r0.value = 32'd10;
          ChR:                             push_data.r0.value = 32'd13;
          ChT:                             push_data.r0.value = 32'd9;
          ChV:                             push_data.r0.value = 32'd11;
          default: begin
            if (is_oct) n_res = 2'd0;
            else push_data.r0.status = csed_pkg::ST_BAD_ESC;
          end
        endcase
      end
      csed_pkg::PH_CR: begin
        if (in_byte != ChLf) begin
          n_res        = {1'b0, f_emit};
          push_data.r0 = f_res;
        end
      end
      csed_pkg::PH_OCT: begin
        if (is_oct) begin
          if (oct_cnt == 2'd3) begin
            n_res              = 2'd1;
            push_data.r0.value = {accum_r[28:0], in_byte[2:0]};
          end
        end else begin
          n_res              = f_emit ? 2'd2 : 2'd1;
          push_data.r0.value = accum_r;
        end
      end
      csed_pkg::PH_HEX: begin
        if (!hex_ok) begin
          n_res = f_emit ? 2'd2 : 2'd1;
          if (cnt_r < 2'd2) push_data.r0.status = csed_pkg::ST_SHORT_HEX;
          else push_data.r0.value = accum_r;
        end
      end
      default: begin
        n_res        = {1'b0, f_emit};
        push_data.r0 = f_res;
      end
    endcase
    push_data.two = (n_res == 2'd2);
  end

  assign push = accept && (n_res != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csed_pkg::PH_IDLE;
      accum_r <= 32'd0;
      cnt_r   <= 2'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `CSED_ASSERT(a_oct_count, clk, rst_n,
    (phase_r != csed_pkg::PH_OCT) || (cnt_r == 2'd1) || (cnt_r == 2'd2),
    "octal escape pending with bad digit count")

endmodule

// ===== src/csed_queue.sv =====
`include "c_escape_sequence_decoder_top_defines.svh"

module csed_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  csed_pkg::entry_t  push_data,
  output logic              full,
  input  logic              pop,
  output csed_pkg::q_head_t q_head
);

  localparam int PtrW = $clog2(csed_pkg::QueueDepth);
  localparam int CntW = $clog2(csed_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] Depth = CntW'(csed_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(csed_pkg::QueueDepth - 1);

  csed_pkg::entry_t mem_r [csed_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  assign full         = (count_r == Depth);
  assign q_head.valid = (count_r != '0);
  assign q_head.head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `CSED_ASSERT(a_count_bound, clk, rst_n, count_r <= Depth,
    "queue count above depth")
  `CSED_ASSERT(a_no_bad_access, clk, rst_n, !(push && full) && !(pop && !q_head.valid),
    "queue overflow or underflow")
  `CSED_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1,
    "queue count did not follow push")

endmodule

// ===== src/csed_back.sv =====
`include "c_escape_sequence_decoder_top_defines.svh"

module csed_back (
  input  logic              clk,
  input  logic              rst_n,
  input  csed_pkg::q_head_t q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_char_value,
  output logic [1:0]        out_status,
  output logic              out_last
);

  logic              sel_r, sel_nxt;
  logic              out_valid_r, out_valid_nxt;
  csed_pkg::result_t res_r;
  logic              last_r;
  logic              load;
  csed_pkg::result_t cur;

  assign load = q_head.valid && (!out_valid_r || out_ready);
  assign cur  = sel_r ? q_head.head.r1 : q_head.head.r0;
  assign pop  = load && (!q_head.head.two || sel_r);

  always_comb begin
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      sel_nxt       = q_head.head.two && !sel_r;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= cur;
      last_r <= pop;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_value = res_r.value;
  assign out_status     = res_r.status;
  assign out_last       = last_r;

  `CSED_ASSERT(a_second_half, clk, rst_n, !sel_r || (q_head.valid && q_head.head.two),
    "second result pending without a two-result entry")

endmodule

// ===== src/c_escape_sequence_decoder_top.sv =====
// c string literal escape decoder
// input channel: in_valid / in_ready / in_byte, one raw byte of the literal
// body per transaction. result channel: out_valid / out_ready with
// out_char_value, out_status (0 char, 1 end, 2 bad escape, 3 short hex)
// and out_last, set on the final result that a byte gives.
// a byte gives zero, one or two results. the front decodes one byte per
// cycle while the queue has room and pushes its results as one entry into
// a two-entry queue; the back sends them out one per cycle, while the
// receiver is ready, through an output register. each result passes the
// queue and then the output register. throughput: one byte per cycle while
// bytes give at most one result each and the receiver is ready; a byte that
// gives two results sends both through the single output register in turn.
// when the receiver stalls, the output register holds, the queue fills and
// in_ready drops once both entries are taken; bytes that give no result
// are still taken only while the queue has room.
// reset (rst_n low, synchronous) empties the queue, clears out_valid and
// returns the decoder to the idle phase with no escape pending.
module c_escape_sequence_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_char_value,
  output logic [1:0]  out_status,
  output logic        out_last
);

  logic              push;
  csed_pkg::entry_t  push_data;
  logic              full;
  logic              pop;
  csed_pkg::q_head_t q_head;

  assign in_ready = !full;

  csed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .push      (push),
    .push_data (push_data)
  );

  csed_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_head    (q_head)
  );

  csed_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_value (out_char_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

// ===== tb/tb_c_escape_sequence_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_c_escape_sequence_decoder_top;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BSL = 8'h5C;

  localparam int RANDOM_BYTES = 750;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 500;

  localparam string SIMPLE_ESC = "'\"?\\abfnrtv";
  localparam string HEX_DIGITS = "0123456789abcdefABCDEF";

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic        last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_char_value;
  logic [1:0]  out_status;
  logic        out_last;

  c_escape_sequence_decoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_value (out_char_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0] byte_q[$];
  decoded_t   decoded_q[$];
  decoded_t   step_q[$];
  decoded_t   want;

  // decoder state as the block should hold it
  csed_pkg::phase_t esc_phase = csed_pkg::PH_IDLE;
  logic [31:0]      esc_accum = '0;
  logic [1:0]       esc_digits = '0;

  int bytes_sent;
  int errors;
  int status_seen[4];
  int in_gap;
  int in_quiet;
  int out_stall;
  int out_stall_next;
  int out_quiet;
  int idle_cycles;

  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic void emit_result(logic [31:0] value, logic [1:0] status);
    decoded_t d;
    d.value  = (status == csed_pkg::ST_CHAR) ? value : 32'd0;
    d.status = status;
    d.last   = 1'b0;
    step_q.push_back(d);
  endfunction

  function automatic int hex_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  function automatic void take_plain(logic [7:0] b);
    esc_phase = csed_pkg::PH_IDLE;
    if (b == CH_NUL) emit_result(32'd0, csed_pkg::ST_END);
    else if (b == CH_BSL) esc_phase = csed_pkg::PH_ESC;
    else emit_result({24'd0, b}, csed_pkg::ST_CHAR);
  endfunction

  function automatic void take_escape(logic [7:0] b);
    esc_phase = csed_pkg::PH_IDLE;
    case (b)
      "'", "\"", "?", CH_BSL: emit_result({24'd0, b}, csed_pkg::ST_CHAR);
      CH_CR: esc_phase = csed_pkg::PH_CR;
      CH_LF: ;
      "a": emit_result(32'd7, csed_pkg::ST_CHAR);
      "b": emit_result(32'd8, csed_pkg::ST_CHAR);
      "f": emit_result(32'd12, csed_pkg::ST_CHAR);
      "n": emit_result(32'd10, csed_pkg::ST_CHAR);
      "r": emit_result(32'd13, csed_pkg::ST_CHAR);
      "t": emit_result(32'd9, csed_pkg::ST_CHAR);
      "v": emit_result(32'd11, csed_pkg::ST_CHAR);
      "x": begin
        esc_phase  = csed_pkg::PH_HEX;
        esc_accum  = '0;
        esc_digits = '0;
      end
      default: begin
        if (b >= "0" && b <= "7") begin
          esc_phase  = csed_pkg::PH_OCT;
          esc_accum  = {29'd0, b[2:0]};
          esc_digits = 2'd1;
        end else begin
          emit_result(32'd0, csed_pkg::ST_BAD_ESC);
        end
      end
    endcase
  endfunction

  // works out the results of one accepted byte and queues them
  function automatic void decode_byte(logic [7:0] b);
    int digit;
    decoded_t tail;
    step_q.delete();
    case (esc_phase)
      csed_pkg::PH_ESC: take_escape(b);
      csed_pkg::PH_CR: begin
        esc_phase = csed_pkg::PH_IDLE;
        if (b != CH_LF) take_plain(b);
      end
      csed_pkg::PH_OCT: begin
        if (b >= "0" && b <= "7") begin
          esc_accum  = {esc_accum[28:0], b[2:0]};
          esc_digits = esc_digits + 2'd1;
          if (esc_digits == 2'd3) begin
            emit_result(esc_accum, csed_pkg::ST_CHAR);
            esc_phase = csed_pkg::PH_IDLE;
          end
        end else begin
          emit_result(esc_accum, csed_pkg::ST_CHAR);
          take_plain(b);
        end
      end
      csed_pkg::PH_HEX: begin
        digit = hex_value(b);
        if (digit >= 0) begin
          esc_accum = {esc_accum[27:0], digit[3:0]};
          if (esc_digits < 2'd2) esc_digits = esc_digits + 2'd1;
        end else begin
          if (esc_digits < 2'd2) emit_result(32'd0, csed_pkg::ST_SHORT_HEX);
          else emit_result(esc_accum, csed_pkg::ST_CHAR);
          take_plain(b);
        end
      end
      default: take_plain(b);
    endcase
    if (step_q.size() > 0) begin
      tail = step_q.pop_back();
      tail.last = 1'b1;
      step_q.push_back(tail);
    end
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) byte_q.push_back(s[i]);
  endfunction

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_valid <= 1'b1;
          in_byte <= byte_q.pop_front();
          in_gap <= draw_wait(in_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("result with nothing expected: value %h status %0d last %0d",
               out_char_value, out_status, out_last);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_char_value !== want.value) begin
          $error("out_char_value: expected %h, got %h", want.value, out_char_value);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
        status_seen[want.status]++;
      end
      out_stall_next = draw_wait(out_quiet);
      out_stall <= out_stall_next;
      out_ready <= (out_stall_next == 0);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= (out_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ends the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("run stalled after %0d bytes with %0d results still owed, %0d mismatches",
                 bytes_sent, decoded_q.size(), errors);
        $display("tb_c_escape_sequence_decoder_top: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int kind;
    int n;
    int directed_len;

    // plain bytes at the extremes, then the corner escapes
    push_text("A");
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h80);
    byte_q.push_back(8'h01);
    push_text("\\q");
    push_text("\\");
    byte_q.push_back(CH_NUL);
    push_text("\\\015B\\\015\012\\\012");
    push_text("\\n\\377\\09");
    push_text("\\x\\t\\xF");
    byte_q.push_back(CH_NUL);
    push_text("\\x123456789a\"");
    directed_len = byte_q.size();

    // mostly well-formed escapes with random content, some noise
    while (byte_q.size() < directed_len + RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        byte_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 45) begin
        byte_q.push_back(CH_BSL);
        byte_q.push_back(SIMPLE_ESC[$urandom_range(0, SIMPLE_ESC.len() - 1)]);
      end else if (kind < 52) begin
        byte_q.push_back(CH_BSL);
        case ($urandom_range(0, 2))
          0: byte_q.push_back(CH_LF);
          1: begin
            byte_q.push_back(CH_CR);
            byte_q.push_back(CH_LF);
          end
          default: begin
            byte_q.push_back(CH_CR);
            byte_q.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end else if (kind < 67) begin
        byte_q.push_back(CH_BSL);
        n = $urandom_range(1, 3);
        repeat (n) byte_q.push_back(8'("0" + $urandom_range(0, 7)));
        if (n < 3 || $urandom_range(0, 1) == 0) byte_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 87) begin
        byte_q.push_back(CH_BSL);
        byte_q.push_back("x");
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 11) : $urandom_range(0, 3);
        repeat (n) byte_q.push_back(HEX_DIGITS[$urandom_range(0, HEX_DIGITS.len() - 1)]);
        byte_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 94) begin
        byte_q.push_back(CH_BSL);
        byte_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        byte_q.push_back(CH_NUL);
      end
    end
    // stream stops inside a hex escape, which must give nothing
    push_text("\\x7");

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes decoded into %0d characters and %0d end marks",
             bytes_sent, status_seen[csed_pkg::ST_CHAR], status_seen[csed_pkg::ST_END]);
    $display("%0d bad escapes and %0d short hex escapes seen, %0d mismatches",
             status_seen[csed_pkg::ST_BAD_ESC], status_seen[csed_pkg::ST_SHORT_HEX], errors);
    if (errors == 0) begin
      $display("tb_c_escape_sequence_decoder_top: clean");
    end else begin
      $display("tb_c_escape_sequence_decoder_top: errors");
    end
    $finish;
  end

endmodule
